// File: hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam int CFG_W    = 7;
  localparam int ENTRY_IW = 6;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 32;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // item function codes
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_SCAN  = 1'b1
  } func_t;

endpackage : mbps_pkg

`default_nettype wire

// File: hdl/mbps_if.sv
// ----------------------------------------------------------------------------
// mbps_if
// Valid/ready channels of the masked byte pattern scanner: input items,
// results and the pattern length register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_item_if
  import mbps_pkg::*;
();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [ENTRY_IW-1:0] entry_index;
  logic [BYTE_W-1:0]   entry_value;
  logic                entry_care;
  logic [BYTE_W-1:0]   scan_byte;
  logic                last_byte;

  modport source (output valid, func, entry_index, entry_value, entry_care,
                  scan_byte, last_byte, input ready);
  modport sink   (input valid, func, entry_index, entry_value, entry_care,
                  scan_byte, last_byte, output ready);
endinterface : mbps_item_if

interface mbps_result_if
  import mbps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface : mbps_result_if

interface mbps_cfg_if
  import mbps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : mbps_cfg_if

`default_nettype wire

// File: hdl/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Wildcard byte signature scan: shift-and match of a byte stream against a
// loaded pattern of byte values with per-entry care bits.
// ----------------------------------------------------------------------------
// output: a result is in the output register in the cycle after its byte
// throughput: one item per cycle; all pattern cells update in parallel in
//   the cycle the byte is accepted, stalls only while a result waits unread
// reset: synchronous; clears partial matches, position, found flag, output
//   valid and sets pattern length to 1; pattern entries hold until written
`default_nettype none

module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mbps_cfg_if.sink      cfg,
  mbps_item_if.sink     item,
  mbps_result_if.source result
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_W-1:0]       pattern_length;
  logic [BYTE_W-1:0]      pattern_value [MAX_PATTERN];
  logic                   pattern_care  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] partial_match;
  logic [POS_W-1:0]       byte_position;
  logic                   found_flag;

  logic                   res_valid;
  logic                   res_found;
  logic [POS_W-1:0]       res_offset;

  logic                   accept;
  logic                   scan_go;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] partial_match_next;
  logic [POS_W-1:0]       len_m1;
  logic                   full_match;
  logic                   emit;
  logic [IDX_W-1:0]       wr_idx;
  logic                   wr_ok;

  assign cfg.ready  = 1'b1;
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign scan_go    = accept && (item.func == FUNC_SCAN) && !found_flag;

  // effective length minus one: zero length acts as one, clamp to depth
  always_comb begin
    if (pattern_length == '0) begin
      len_m1 = '0;
    end else if (POS_W'(pattern_length) > POS_W'(MAX_PATTERN)) begin
      len_m1 = POS_W'(MAX_PATTERN - 1);
    end else begin
      len_m1 = POS_W'(pattern_length) - POS_W'(1);
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign hit[k] = !pattern_care[k] || (item.scan_byte == pattern_value[k]);
    if (k == 0) begin : g_head
      assign partial_match_next[k] = hit[k];
    end else begin : g_tail
      assign partial_match_next[k] = partial_match[k-1] && hit[k];
    end
  end

  assign full_match = partial_match_next[len_m1[IDX_W-1:0]];
  assign emit       = scan_go && (full_match || item.last_byte);

  assign wr_idx = IDX_W'(item.entry_index);
  assign wr_ok  = POS_W'(item.entry_index) < POS_W'(MAX_PATTERN);

  // pattern store, no reset
  always_ff @(posedge clk) begin
    if (accept && (item.func == FUNC_WRITE) && wr_ok) begin
      pattern_value[wr_idx] <= item.entry_value;
      pattern_care[wr_idx]  <= item.entry_care;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= CFG_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      pattern_length <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_match <= '0;
      byte_position <= '0;
      found_flag    <= 1'b0;
    end else if (accept && (item.func == FUNC_SCAN)) begin
      if (item.last_byte) begin
        // last byte always restarts the search
        partial_match <= '0;
        byte_position <= '0;
        found_flag    <= 1'b0;
      end else if (!found_flag) begin
        partial_match <= partial_match_next;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
        if (full_match) begin
          found_flag <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_found  <= full_match;
      res_offset <= full_match ? (byte_position - len_m1) : '0;
    end
  end

  assign result.valid        = res_valid;
  assign result.found        = res_found;
  assign result.match_offset = res_offset;

endmodule : masked_byte_pattern_scan

`default_nettype wire

// File: hdl/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks for the masked byte pattern scanner, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_checker
  import mbps_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire logic             item_func,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire logic             result_found,
  input wire logic [POS_W-1:0] result_match_offset
);

  logic item_xfer;
  logic result_stall;

  assign item_xfer    = item_valid && item_ready;
  assign result_stall = result_valid && !result_ready;

  // a stalled result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_stall |=> result_valid && $stable(result_found)
                     && $stable(result_match_offset))
    else $error("result changed while stalled");

  // not found always carries a zero offset
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_found |-> result_match_offset == '0)
    else $error("not found result with nonzero offset");

  // a new result needs an item transfer in the cycle before
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_xfer))
    else $error("result without a preceding item transfer");

  // pattern writes never produce a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    item_xfer && (item_func == FUNC_WRITE) && !result_stall |=> !result_valid)
    else $error("pattern write produced a result");

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule : mbps_checker

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_valid          (item.valid),
  .item_ready          (item.ready),
  .item_func           (item.func),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_found        (result.found),
  .result_match_offset (result.match_offset)
);

`default_nettype wire
